// ===== sv/prd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package prd_pkg;

    localparam int WINDOW_LEN = 15;
    localparam int IDX_W      = $clog2(WINDOW_LEN);

    localparam int SAMPLE_W   = 12;
    localparam int LEVEL_W    = 8;
    localparam int DIFF_W     = LEVEL_W + 1;
    localparam int THR_W      = 12;
    localparam int NUM_W      = 16;
    localparam int COUNT_W    = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP = 8'd232;
    localparam int LEVEL_SPAN = 227;
    localparam int SUM_MAX    = WINDOW_LEN * LEVEL_SPAN;
    localparam int SUM_W      = $clog2(SUM_MAX + 1) + 1;
    localparam int CMP_W      = (SUM_W > THR_W + 1) ? SUM_W : THR_W + 1;

    // 65536 / 18 rounded up; exact floor for every 12-bit sample
    localparam logic [SAMPLE_W-1:0] LEVEL_RECIP = 12'd3641;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [THR_W-1:0] THR_RESET = 12'd40;
    localparam logic [NUM_W-1:0] NUM_RESET = 16'd6000;

    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 1'b1;

    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [NUM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/prd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire                     re,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/prd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prd_div
    import prd_pkg::*;
(
    input  wire      clk,
    input  wire      rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [NUM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     dvs_reg;

    logic [NUM_W:0]       rem_sh;
    logic [NUM_W:0]       trial;

    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign trial  = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[NUM_W])
            begin
                rem_reg <= trial[NUM_W-1:0];
            end
            else
            begin
                rem_reg <= rem_sh[NUM_W-1:0];
            end
            quo_reg <= {quo_reg[NUM_W-2:0], ~trial[NUM_W]};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== sv/pulse_rate_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Port group    | Handshake            | Payload
// --------------+----------------------+--------------------------------------
// cfg           | cfg_we               | cfg_index, cfg_data
// in            | in_valid / in_stall  | adc_sample
// out           | out_valid / out_stall| rate_valid, rate, level, pulse_active
//
// One transaction at a time: the result reaches the output register through the
// LEVEL, UPDATE, DECIDE and OUT states, with DIV before OUT when an onset runs
// the 16-step shift-subtract divider; the next sample is taken in IDLE again.
// The difference ring sits in a 15-entry RAM with a registered read port;
// per-entry valid flops make unwritten entries read as zero, so no clear pass.
// rst_n is asynchronous; configuration returns to threshold 40, numerator 6000.
// in_stall is high while a transaction is in work; a result waits in the
// output register under out_stall while the next sample is already taken.

module pulse_rate_detector
    import prd_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [NUM_W-1:0]      cfg_data,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire [SAMPLE_W-1:0]   adc_sample,
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic                 rate_valid,
    output logic [NUM_W-1:0]     rate,
    output logic [LEVEL_W-1:0]   level,
    output logic                 pulse_active
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LEVEL  = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;

    logic [THR_W-1:0]        thr_reg;
    logic [NUM_W-1:0]        num_reg;

    logic [SAMPLE_W-1:0]     sample_reg;
    logic [LEVEL_W-1:0]      level_reg;
    logic [LEVEL_W-1:0]      prev_reg;
    logic                    primed_reg;
    logic                    prime_step_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [WINDOW_LEN-1:0]   ring_vld_reg;
    logic signed [SUM_W-1:0] total_reg;
    logic                    flag_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic                    res_valid_reg;
    logic [NUM_W-1:0]        res_rate_reg;

    logic                    out_valid_reg;
    logic                    rate_valid_reg;
    logic [NUM_W-1:0]        rate_reg;
    logic [LEVEL_W-1:0]      out_level_reg;
    logic                    pulse_reg;

    logic                    in_accept;
    logic                    out_load;
    logic [PROD_W-1:0]       prod;
    logic [LEVEL_W-1:0]      level_calc;
    logic [DIFF_W-1:0]       diff;
    logic [DIFF_W-1:0]       ram_rdata;
    logic [DIFF_W-1:0]       old_diff;
    logic signed [SUM_W-1:0] total_next;
    logic signed [CMP_W-1:0] total_x;
    logic signed [CMP_W-1:0] thr_x;
    logic                    above;
    logic                    ram_we;
    logic [IDX_W-1:0]        idx_next;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    assign prod       = sample_reg * PROD_W'(LEVEL_RECIP);
    assign level_calc = LEVEL_TOP - prod[RECIP_SHIFT +: LEVEL_W];

    assign diff       = {1'b0, level_reg} - {1'b0, prev_reg};
    assign old_diff   = ring_vld_reg[idx_reg] ? ram_rdata : '0;
    assign total_next = total_reg - SUM_W'($signed(old_diff)) + SUM_W'($signed(diff));
    assign ram_we     = (state_reg == S_UPDATE) && primed_reg;
    assign idx_next   = (idx_reg == IDX_W'(WINDOW_LEN - 1)) ? '0 : idx_reg + 1'b1;

    assign total_x    = CMP_W'(total_reg);
    assign thr_x      = $signed(CMP_W'(thr_reg));
    assign above      = (total_x >= thr_x);

    assign div_req.start    = (state_reg == S_DECIDE) && !prime_step_reg && !flag_reg
                              && above && (count_reg != '0);
    assign div_req.dividend = num_reg;
    assign div_req.divisor  = count_reg;

    prd_ram #(
        .DEPTH (WINDOW_LEN),
        .WIDTH (DIFF_W)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (diff),
        .re    (in_accept),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    prd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_LEVEL;
                end
            end
            S_LEVEL:  state_next = S_UPDATE;
            S_UPDATE: state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (div_req.start)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thr_reg        <= THR_RESET;
            num_reg        <= NUM_RESET;
            prev_reg       <= '0;
            primed_reg     <= 1'b0;
            prime_step_reg <= 1'b0;
            idx_reg        <= '0;
            ring_vld_reg   <= '0;
            total_reg      <= '0;
            flag_reg       <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                    CFG_NUMERATOR: num_reg <= cfg_data;
                    default:       ;
                endcase
            end

            if (state_reg == S_UPDATE)
            begin
                prev_reg       <= level_reg;
                prime_step_reg <= !primed_reg;
                primed_reg     <= 1'b1;
                if (primed_reg)
                begin
                    total_reg             <= total_next;
                    ring_vld_reg[idx_reg] <= 1'b1;
                    idx_reg               <= idx_next;
                end
            end

            if ((state_reg == S_DECIDE) && !prime_step_reg)
            begin
                if (!flag_reg && above)
                begin
                    flag_reg  <= 1'b1;
                    count_reg <= '0;
                end
                else
                begin
                    if (!above)
                    begin
                        flag_reg <= 1'b0;
                    end
                    if (count_reg != COUNT_MAX)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= adc_sample;
        end

        if (state_reg == S_LEVEL)
        begin
            level_reg <= level_calc;
        end

        if (state_reg == S_DECIDE)
        begin
            res_valid_reg <= div_req.start;
            res_rate_reg  <= '0;
        end
        else if ((state_reg == S_DIV) && div_rsp.done)
        begin
            res_rate_reg <= div_rsp.quotient;
        end

        if (out_load)
        begin
            rate_valid_reg <= res_valid_reg;
            rate_reg       <= res_rate_reg;
            out_level_reg  <= level_reg;
            pulse_reg      <= flag_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rate_valid   = rate_valid_reg;
    assign rate         = rate_reg;
    assign level        = out_level_reg;
    assign pulse_active = pulse_reg;

endmodule

`default_nettype wire

// ===== tb/pulse_rate_detector_test.sv =====
`timescale 1ns / 1ps

module pulse_rate_detector_test;
    import prd_pkg::*;

    localparam int LEVEL_STEP    = 18;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_ITEMS   = 200;
    localparam int PHASE_COUNT   = 8;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        logic               rate_valid;
        logic [NUM_W-1:0]   rate;
        logic [LEVEL_W-1:0] level;
        logic               pulse_active;
    } beat_t;

    typedef struct {
        row_kind_t              kind;
        logic [NUM_W-1:0]       value;
        logic [CFG_IDX_W-1:0]   reg_sel;
        logic                   typed;
        beat_t                  golden;
    } row_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [NUM_W-1:0]      cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   adc_sample = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic                  rate_valid;
    logic [NUM_W-1:0]      rate;
    logic [LEVEL_W-1:0]    level;
    logic                  pulse_active;

    int gap_pct      = 0;
    int stall_pct    = 0;
    int mismatches   = 0;
    int samples_sent = 0;

    beat_t beats_due[$];

    logic [LEVEL_W-1:0] last_level = '0;
    logic               primed     = 1'b0;
    int                 diffs [WINDOW_LEN] = '{default: 0};
    int                 ring_pos   = 0;
    int                 win_sum    = 0;
    logic               onset      = 1'b0;
    logic [COUNT_W-1:0] ticks      = '0;
    logic [THR_W-1:0]   thr        = THR_RESET;
    logic [NUM_W-1:0]   numer      = NUM_RESET;

    pulse_rate_detector uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .adc_sample   (adc_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rate_valid   (rate_valid),
        .rate         (rate),
        .level        (level),
        .pulse_active (pulse_active)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic beat_t predict_beat(input logic [SAMPLE_W-1:0] s);
        beat_t r;
        int    lvl;
        int    step;
        r   = '0;
        lvl = int'(LEVEL_TOP) - int'(s) / LEVEL_STEP;
        r.level = lvl[LEVEL_W-1:0];
        if (!primed)
        begin
            primed = 1'b1;
            last_level = lvl[LEVEL_W-1:0];
            r.pulse_active = onset;
            return r;
        end
        step = lvl - int'(last_level);
        win_sum = win_sum - diffs[ring_pos] + step;
        diffs[ring_pos] = step;
        ring_pos = (ring_pos + 1) % WINDOW_LEN;
        if (!onset && win_sum >= int'(thr))
        begin
            onset = 1'b1;
            if (ticks != 0)
            begin
                r.rate_valid = 1'b1;
                r.rate = numer / ticks;
            end
            ticks = '0;
        end
        else
        begin
            if (win_sum < int'(thr))
                onset = 1'b0;
            if (ticks != COUNT_MAX)
                ticks = ticks + 1'b1;
        end
        last_level = lvl[LEVEL_W-1:0];
        r.pulse_active = onset;
        return r;
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin gap_pct = 84; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 84; end
            default:       begin gap_pct = 24; stall_pct = 24; end
        endcase
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                               input beat_t golden);
        beat_t due;
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid   <= 1'b1;
        adc_sample <= s;
        do
            @(posedge clk);
        while (in_stall);
        due = predict_beat(s);
        beats_due.push_back(typed ? golden : due);
        samples_sent++;
    endtask

    // hold the sender until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [NUM_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (sel == CFG_THRESHOLD)
            thr = data[THR_W-1:0];
        else
            numer = data;
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin : check_results
        beat_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (beats_due.size() == 0)
            begin
                $error("unexpected transaction: level %0d rate %0d", level, rate);
                mismatches++;
            end
            else
            begin
                due = beats_due.pop_front();
                if (rate_valid !== due.rate_valid)
                begin
                    $error("rate_valid: expected %0d, actual %0d", due.rate_valid, rate_valid);
                    mismatches++;
                end
                if (rate !== due.rate)
                begin
                    $error("rate: expected %0d, actual %0d", due.rate, rate);
                    mismatches++;
                end
                if (level !== due.level)
                begin
                    $error("level: expected %0d, actual %0d", due.level, level);
                    mismatches++;
                end
                if (pulse_active !== due.pulse_active)
                begin
                    $error("pulse_active: expected %0d, actual %0d", due.pulse_active,
                           pulse_active);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        row_t plan[$];
        int   base;
        int   depth;
        int   rise;
        int   per;
        int   v;
        int   thr_pick;
        int   num_pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan.push_back('{ROW_SAMPLE, 16'd4095,  CFG_THRESHOLD, 1'b1, '{1'b0, 16'd0,     8'd5,   1'b0}});
        plan.push_back('{ROW_SAMPLE, 16'd0,     CFG_THRESHOLD, 1'b1, '{1'b0, 16'd0,     8'd232, 1'b1}});
        plan.push_back('{ROW_SAMPLE, 16'd0,     CFG_THRESHOLD, 1'b1, '{1'b0, 16'd0,     8'd232, 1'b1}});
        plan.push_back('{ROW_SAMPLE, 16'd4095,  CFG_THRESHOLD, 1'b1, '{1'b0, 16'd0,     8'd5,   1'b0}});
        plan.push_back('{ROW_SAMPLE, 16'd0,     CFG_THRESHOLD, 1'b1, '{1'b1, 16'd3000,  8'd232, 1'b1}});
        plan.push_back('{ROW_SAMPLE, 16'd4095,  CFG_THRESHOLD, 1'b1, '{1'b0, 16'd0,     8'd5,   1'b0}});
        plan.push_back('{ROW_SAMPLE, 16'd0,     CFG_THRESHOLD, 1'b1, '{1'b1, 16'd6000,  8'd232, 1'b1}});
        plan.push_back('{ROW_WRITE,  16'd0,     CFG_NUMERATOR, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, 16'd4095,  CFG_THRESHOLD, 1'b1, '{1'b0, 16'd0,     8'd5,   1'b0}});
        plan.push_back('{ROW_SAMPLE, 16'd0,     CFG_THRESHOLD, 1'b1, '{1'b1, 16'd0,     8'd232, 1'b1}});
        plan.push_back('{ROW_WRITE,  16'd65535, CFG_NUMERATOR, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, 16'd4095,  CFG_THRESHOLD, 1'b1, '{1'b0, 16'd0,     8'd5,   1'b0}});
        plan.push_back('{ROW_SAMPLE, 16'd0,     CFG_THRESHOLD, 1'b1, '{1'b1, 16'd65535, 8'd232, 1'b1}});
        plan.push_back('{ROW_WRITE,  16'd0,     CFG_THRESHOLD, 1'b0, '0});
        plan.push_back('{ROW_WRITE,  16'd6000,  CFG_NUMERATOR, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, 16'd17,    CFG_THRESHOLD, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, 16'd18,    CFG_THRESHOLD, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, 16'd4086,  CFG_THRESHOLD, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, 16'd4085,  CFG_THRESHOLD, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, 16'd2730,  CFG_THRESHOLD, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, 16'd1365,  CFG_THRESHOLD, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, 16'd4095,  CFG_THRESHOLD, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, 16'd0,     CFG_THRESHOLD, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, 16'd1000,  CFG_THRESHOLD, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, 16'd3000,  CFG_THRESHOLD, 1'b0, '0});

        set_idling(IDLE_NONE);
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                drain();
                write_reg(plan[i].reg_sel, plan[i].value);
            end
            else
                send_sample(plan[i].value[SAMPLE_W-1:0], plan[i].typed, plan[i].golden);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain();
            case (ph)
                0:       begin thr_pick = 40;   num_pick = 6000;  end
                1:       begin thr_pick = 0;    num_pick = 1;     end
                2:       begin thr_pick = 4095; num_pick = 65535; end
                3:       begin thr_pick = $urandom_range(20, 300);
                               num_pick = $urandom_range(1, 65535); end
                4:       begin thr_pick = 1;    num_pick = $urandom_range(1, 65535); end
                5:       begin thr_pick = $urandom_range(0, 4095);
                               num_pick = $urandom_range(0, 65535); end
                6:       begin thr_pick = 40;   num_pick = 6000;  end
                default: begin thr_pick = $urandom_range(20, 120);
                               num_pick = $urandom_range(100, 65535); end
            endcase
            write_reg(CFG_THRESHOLD, {4'($urandom), thr_pick[THR_W-1:0]});
            write_reg(CFG_NUMERATOR, num_pick[NUM_W-1:0]);
            set_idling(idle_mode_t'(ph % 4));
            samples_sent = 0;
            while (samples_sent < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 80)
                begin
                    // sharp upstroke, slow decay, some jitter
                    base  = $urandom_range(1500, 4095);
                    depth = $urandom_range(0, base);
                    rise  = $urandom_range(1, 4);
                    per   = ($urandom_range(9) == 0) ? $urandom_range(60, 250)
                                                     : $urandom_range(rise + 1, 40);
                    for (int k = 0; k < per; k++)
                    begin
                        if (k < rise)
                            v = base - depth * (k + 1) / rise;
                        else
                            v = base - depth + depth * (k - rise + 1) / (per - rise);
                        v = v + $urandom_range(0, 40) - 20;
                        if (v < 0)
                            v = 0;
                        if (v > 4095)
                            v = 4095;
                        send_sample(v[SAMPLE_W-1:0], 1'b0, '0);
                    end
                end
                else
                    repeat ($urandom_range(1, 10))
                        send_sample(12'($urandom_range(0, 4095)), 1'b0, '0);
            end
        end

        drain();

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
